>>> sv/dat_pkg.sv
// ----------------------------------------------------------------------------
// Dumper angle tracker package
// Shared types, codes and constants for the dumper angle tracker.
// ----------------------------------------------------------------------------
package dat_pkg;

  localparam int unsigned TICK_SHIFT    = 10;
  localparam int unsigned TICKS_PER_SEC = 1 << TICK_SHIFT;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned TICK_W  = 32;
  localparam int unsigned ANGLE_W = 24;
  localparam int unsigned MSTEP_W = 9;
  localparam int unsigned RATE_W  = 16;

  localparam logic [MSTEP_W-1:0] MSTEP_RESET = 9'd16;

  // floor(y / 3) == (y * PULSE_RECIP) >> 16 for every 15-bit y.
  localparam logic [14:0] PULSE_RECIP = 15'd21846;

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 24'sh7FFFFF;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = -24'sh800000;

  typedef enum logic [1:0] {
    MODE_HORIZ = 2'd0,
    MODE_UP    = 2'd1,
    MODE_DOWN  = 2'd2,
    MODE_TOP   = 2'd3
  } dat_mode_e;

  typedef enum logic [1:0] {
    REQ_UP    = 2'd0,
    REQ_DOWN  = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_QUERY = 2'd3
  } dat_req_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_BUSY  = 2'd1,
    STATUS_FAULT = 2'd2
  } dat_status_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [SPEED_W-1:0] speed;
    logic [TICK_W-1:0]  now_tick;
    logic               at_home;
  } dat_req_t;

  typedef struct packed {
    logic [1:0]                status;
    logic                      motor_run;
    logic                      motor_dir;
    logic [RATE_W-1:0]         pulse_rate;
    logic signed [ANGLE_W-1:0] angle;
    logic [1:0]                mode;
  } dat_rsp_t;

  typedef struct packed {
    logic [1:0]                mode;
    logic signed [ANGLE_W-1:0] stored_angle;
    logic [SPEED_W-1:0]        move_speed;
    logic [TICK_W-1:0]         start_tick;
    logic                      run;
    logic                      dir;
  } dat_state_t;

endpackage

>>> sv/dumper_angle_tracker_unit.sv
// ----------------------------------------------------------------------------
// Dumper angle tracker unit
// Tilt actuator mode machine with a dead-reckoned angle estimate.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   in_data_i   (dat_req_t)
//   out       output     out_valid_o / out_ready_i out_data_o  (dat_rsp_t)
//   cfg       input      cfg_we_i                  cfg_wdata_i (microstep mode)
//
// An item is held in the input register and then passes through the
// logic (one elapsed-angle multiply and the saturating add) into the result
// register, and one item is taken every cycle while the result is not stalled.
// Reset clears the tracker state and loads the microstep mode with 16.
// A stalled result holds both stages; the input side keeps taking items as
// long as the input register is empty or moves on.
// ----------------------------------------------------------------------------
module dumper_angle_tracker_unit
  import dat_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dat_req_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output dat_rsp_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [MSTEP_W-1:0] cfg_wdata_i
);

  logic               in_valid_q, in_valid_d;
  dat_req_t           in_q, in_d;
  logic               out_valid_q, out_valid_d;
  dat_rsp_t           out_q, out_d;
  dat_state_t         state_q, state_d;
  logic [MSTEP_W-1:0] mstep_q, mstep_d;
  dat_state_t         state_nxt;
  dat_rsp_t           rsp;
  logic               advance;
  logic               fire;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !in_valid_q || advance;
  assign fire       = in_valid_q && advance;

  dat_step_logic u_step (
    .state_i     (state_q),
    .req_i       (in_q),
    .microstep_i (mstep_q),
    .state_o     (state_nxt),
    .rsp_o       (rsp)
  );

  always_comb begin
    in_valid_d  = in_valid_q;
    in_d        = in_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    state_d     = state_q;
    mstep_d     = cfg_we_i ? cfg_wdata_i : mstep_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
      if (in_valid_i) begin
        in_d = in_data_i;
      end
    end
    if (advance) begin
      out_valid_d = in_valid_q;
    end
    if (fire) begin
      out_d   = rsp;
      state_d = state_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q           <= 1'b0;
      out_valid_q          <= 1'b0;
      state_q.mode         <= MODE_HORIZ;
      state_q.stored_angle <= '0;
      state_q.move_speed   <= '0;
      state_q.start_tick   <= '0;
      state_q.run          <= 1'b0;
      state_q.dir          <= 1'b0;
      mstep_q              <= MSTEP_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
      mstep_q     <= mstep_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_up_runs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode == MODE_UP |-> state_q.run && !state_q.dir)
    else $error("moving up without the motor running up");

  a_down_runs_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.mode == MODE_DOWN |-> state_q.run && state_q.dir)
    else $error("moving down without the motor running down");

  a_stopped_no_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.motor_run |-> out_data_o.pulse_rate == '0)
    else $error("pulse rate given while the motor is stopped");

  a_busy_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STATUS_BUSY |-> out_data_o.mode == MODE_DOWN)
    else $error("busy reported outside of moving down");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_q))
    else $error("input register lost an item while stalled");

endmodule

>>> sv/dat_pulse_calc.sv
// ----------------------------------------------------------------------------
// Dumper pulse rate calculator
// Converts the move speed into a motor pulse rate at the microstep setting.
// ----------------------------------------------------------------------------
module dat_pulse_calc
  import dat_pkg::*;
(
  input  logic [SPEED_W-1:0] speed_i,
  input  logic [MSTEP_W-1:0] microstep_i,
  input  logic               run_i,
  output logic [RATE_W-1:0]  rate_o
);

  logic [SPEED_W+MSTEP_W-1:0] prod;
  logic [14:0]                scaled;
  logic [29:0]                third;

  // The rate is speed * microstep / 3072, taken as a shift by 1024 and a
  // division by three through a reciprocal multiply.
  assign prod   = speed_i * microstep_i;
  assign scaled = prod[SPEED_W+MSTEP_W-1:10];
  assign third  = scaled * PULSE_RECIP;
  assign rate_o = run_i ? {2'b00, third[29:16]} : '0;

endmodule

>>> sv/dat_step_logic.sv
// ----------------------------------------------------------------------------
// Dumper step logic
// Computes the next tracker state and the result item for one request.
// ----------------------------------------------------------------------------
module dat_step_logic
  import dat_pkg::*;
(
  input  dat_state_t         state_i,
  input  dat_req_t           req_i,
  input  logic [MSTEP_W-1:0] microstep_i,
  output dat_state_t         state_o,
  output dat_rsp_t           rsp_o
);

  logic [TICK_W-1:0]         dt;
  logic [TICK_W+SPEED_W-1:0] prod;
  logic [ANGLE_W:0]          elapsed;
  logic signed [ANGLE_W+2:0] sum;
  logic signed [ANGLE_W-1:0] live;
  logic [1:0]                status;
  logic [RATE_W-1:0]         rate;
  dat_state_t                nxt;
  logic signed [ANGLE_W-1:0] angle;

  assign dt   = req_i.now_tick - state_i.start_tick;
  assign prod = dt * state_i.move_speed;

  always_comb begin
    if (prod[TICK_W+SPEED_W-1:TICK_SHIFT+ANGLE_W] != '0) begin
      elapsed = {1'b1, {ANGLE_W{1'b0}}};
    end else begin
      elapsed = prod[TICK_SHIFT+ANGLE_W:TICK_SHIFT];
    end
  end

  always_comb begin
    case (state_i.mode)
      MODE_UP: begin
        sum = {{3{state_i.stored_angle[ANGLE_W-1]}}, state_i.stored_angle}
              + {2'b00, elapsed};
      end
      MODE_DOWN: begin
        sum = {{3{state_i.stored_angle[ANGLE_W-1]}}, state_i.stored_angle}
              - {2'b00, elapsed};
      end
      default: begin
        sum = {{3{state_i.stored_angle[ANGLE_W-1]}}, state_i.stored_angle};
      end
    endcase
    if (sum > $signed({{3{1'b0}}, ANGLE_MAX})) begin
      live = ANGLE_MAX;
    end else if (sum < $signed({{3{1'b1}}, ANGLE_MIN})) begin
      live = ANGLE_MIN;
    end else begin
      live = sum[ANGLE_W-1:0];
    end
  end

  always_comb begin
    nxt    = state_i;
    status = STATUS_OK;
    angle  = state_i.stored_angle;
    case (req_i.req_type)
      REQ_UP: begin
        nxt.move_speed = req_i.speed;
        nxt.start_tick = req_i.now_tick;
        nxt.mode       = MODE_UP;
        nxt.run        = 1'b1;
        nxt.dir        = 1'b0;
      end
      REQ_DOWN: begin
        if (state_i.mode == MODE_DOWN) begin
          status = STATUS_BUSY;
          angle  = live;
        end else if (req_i.at_home) begin
          nxt.mode = MODE_HORIZ;
          status   = STATUS_FAULT;
        end else begin
          nxt.move_speed = req_i.speed;
          nxt.start_tick = req_i.now_tick;
          nxt.mode       = MODE_DOWN;
          nxt.run        = 1'b1;
          nxt.dir        = 1'b1;
        end
      end
      REQ_STOP: begin
        nxt.run        = 1'b0;
        nxt.start_tick = '0;
        if (state_i.mode == MODE_DOWN && req_i.at_home) begin
          nxt.stored_angle = '0;
          nxt.mode         = MODE_HORIZ;
        end else if (state_i.mode == MODE_DOWN || state_i.mode == MODE_UP) begin
          nxt.stored_angle = live;
          nxt.mode         = MODE_TOP;
        end
        angle = nxt.stored_angle;
      end
      default: begin
        angle = live;
      end
    endcase
  end

  dat_pulse_calc u_pulse (
    .speed_i     (nxt.move_speed),
    .microstep_i (microstep_i),
    .run_i       (nxt.run),
    .rate_o      (rate)
  );

  assign state_o          = nxt;
  assign rsp_o.status     = status;
  assign rsp_o.motor_run  = nxt.run;
  assign rsp_o.motor_dir  = nxt.dir;
  assign rsp_o.pulse_rate = rate;
  assign rsp_o.angle      = angle;
  assign rsp_o.mode       = nxt.mode;

endmodule

>>> sim/dumper_angle_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// Dumper angle tracker unit testbench
// Drives move, stop and query requests through the valid/ready input channel
// and checks every response against a cycle-free model of the mode machine
// and its dead-reckoned angle, across several microstep settings.
// ----------------------------------------------------------------------------
module dumper_angle_tracker_unit_tb;
  import dat_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  dat_req_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  dat_rsp_t           out_data;
  logic               cfg_we = 1'b0;
  logic [MSTEP_W-1:0] cfg_wdata = '0;

  dumper_angle_tracker_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // Tracker state as the block should hold it.
  dat_state_t         trk = '0;
  logic [MSTEP_W-1:0] mstep_now = MSTEP_RESET;

  dat_req_t req_backlog[$];
  dat_rsp_t rsp_due[$];

  int n_queued = 0;
  int n_in = 0;
  int n_rsp = 0;
  int n_err = 0;
  int n_busy = 0;
  int n_fault = 0;
  int n_settings = 1;
  int send_gap = 0;
  int rsp_hold = 0;
  int idle_cycles = 0;
  bit send_calm = 1'b0;
  bit rsp_calm = 1'b0;
  bit long_hold_req = 1'b0;
  logic [TICK_W-1:0] wall_tick = '0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint tilt_since_start(logic [TICK_W-1:0] now);
    logic [TICK_W-1:0] dt;
    logic [63:0]       prod;
    dt = now - trk.start_tick;
    prod = ({32'd0, dt} * {48'd0, trk.move_speed}) >> TICK_SHIFT;
    if (prod > 64'd16777216) prod = 64'd16777216;
    return longint'(prod);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] clamp_angle(longint v);
    if (v > longint'(ANGLE_MAX)) return ANGLE_MAX;
    if (v < longint'(ANGLE_MIN)) return ANGLE_MIN;
    return v[ANGLE_W-1:0];
  endfunction

  function automatic logic signed [ANGLE_W-1:0] angle_estimate(logic [TICK_W-1:0] now);
    if (trk.mode == MODE_UP)
      return clamp_angle(longint'(trk.stored_angle) + tilt_since_start(now));
    if (trk.mode == MODE_DOWN)
      return clamp_angle(longint'(trk.stored_angle) - tilt_since_start(now));
    return trk.stored_angle;
  endfunction

  function automatic logic [RATE_W-1:0] step_rate();
    logic [63:0] prod;
    prod = ({55'd0, mstep_now} * {48'd0, trk.move_speed}) / 64'd3072;
    return (prod > 64'd65535) ? 16'hFFFF : prod[RATE_W-1:0];
  endfunction

  function automatic dat_rsp_t tracker_next(dat_req_t req);
    dat_rsp_t rsp;
    rsp = '0;
    rsp.status = STATUS_OK;
    case (req.req_type)
      REQ_UP: begin
        trk.move_speed = req.speed;
        trk.start_tick = req.now_tick;
        trk.mode = MODE_UP;
        trk.run = 1'b1;
        trk.dir = 1'b0;
      end
      REQ_DOWN: begin
        if (trk.mode == MODE_DOWN) begin
          rsp.status = STATUS_BUSY;
        end else if (req.at_home) begin
          trk.mode = MODE_HORIZ;
          rsp.status = STATUS_FAULT;
        end else begin
          trk.move_speed = req.speed;
          trk.start_tick = req.now_tick;
          trk.mode = MODE_DOWN;
          trk.run = 1'b1;
          trk.dir = 1'b1;
        end
      end
      REQ_STOP: begin
        trk.run = 1'b0;
        if (trk.mode == MODE_DOWN) begin
          if (req.at_home) begin
            trk.stored_angle = '0;
            trk.mode = MODE_HORIZ;
          end else begin
            trk.stored_angle = clamp_angle(longint'(trk.stored_angle) -
                                           tilt_since_start(req.now_tick));
            trk.mode = MODE_TOP;
          end
        end else if (trk.mode == MODE_UP) begin
          trk.stored_angle = clamp_angle(longint'(trk.stored_angle) +
                                         tilt_since_start(req.now_tick));
          trk.mode = MODE_TOP;
        end
        trk.start_tick = '0;
      end
      default: begin
      end
    endcase
    if (rsp.status == STATUS_BUSY) n_busy++;
    if (rsp.status == STATUS_FAULT) n_fault++;
    rsp.motor_run = trk.run;
    rsp.motor_dir = trk.dir;
    rsp.pulse_rate = trk.run ? step_rate() : '0;
    rsp.angle = angle_estimate(req.now_tick);
    rsp.mode = trk.mode;
    return rsp;
  endfunction

  task automatic check_rsp(input dat_rsp_t want, input dat_rsp_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      n_err++;
    end
    if (got.motor_run !== want.motor_run) begin
      $error("motor_run: expected %0d, got %0d", want.motor_run, got.motor_run);
      n_err++;
    end
    if (got.motor_dir !== want.motor_dir) begin
      $error("motor_dir: expected %0d, got %0d", want.motor_dir, got.motor_dir);
      n_err++;
    end
    if (got.pulse_rate !== want.pulse_rate) begin
      $error("pulse_rate: expected %0d, got %0d", want.pulse_rate, got.pulse_rate);
      n_err++;
    end
    if (got.angle !== want.angle) begin
      $error("angle: expected %0d, got %0d", $signed(want.angle), $signed(got.angle));
      n_err++;
    end
    if (got.mode !== want.mode) begin
      $error("mode: expected %0d, got %0d", want.mode, got.mode);
      n_err++;
    end
  endtask

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rsp_due.push_back(tracker_next(in_data));
        n_in++;
      end
      if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_data <= req_backlog.pop_front();
          in_valid <= 1'b1;
          if (!send_calm && $urandom_range(0, 2) == 0) send_gap = gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_rsp++;
        if (rsp_due.size() == 0) begin
          $error("response with no request outstanding");
          n_err++;
        end else begin
          check_rsp(rsp_due.pop_front(), out_data);
        end
      end
      if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_hold = 150;
      end
      if (rsp_hold > 0) begin
        rsp_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rsp_calm && $urandom_range(0, 3) == 0) rsp_hold = gap_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("dumper_angle_tracker_unit_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic dat_req_t mk_req(logic [1:0] kind, logic [SPEED_W-1:0] spd,
                                      logic [TICK_W-1:0] tick, logic home);
    dat_req_t r;
    r.req_type = kind;
    r.speed = spd;
    r.now_tick = tick;
    r.at_home = home;
    return r;
  endfunction

  task automatic push_req(input dat_req_t r);
    req_backlog.push_back(r);
    n_queued++;
  endtask

  function automatic logic [SPEED_W-1:0] pick_speed();
    case ($urandom_range(0, 3))
      0: return SPEED_W'($urandom_range(0, 1024));
      1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return SPEED_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic advance_tick();
    if ($urandom_range(0, 24) == 0) wall_tick = $urandom();
    else wall_tick = wall_tick + $urandom_range(0, 3000);
  endtask

  // Mostly complete move, query and stop sequences with random content,
  // with some fully random requests mixed in.
  task automatic queue_traffic(input int count);
    int added;
    int queries;
    int k;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 4) == 0) begin
        push_req(mk_req(2'($urandom_range(0, 3)), SPEED_W'($urandom_range(0, 65535)),
                        $urandom(), 1'($urandom_range(0, 1))));
        added++;
      end else begin
        advance_tick();
        push_req(mk_req($urandom_range(0, 1) ? REQ_DOWN : REQ_UP, pick_speed(), wall_tick,
                        $urandom_range(0, 7) == 0));
        queries = $urandom_range(0, 3);
        for (k = 0; k < queries; k++) begin
          advance_tick();
          push_req(mk_req((k == 1 && $urandom_range(0, 1)) ? REQ_DOWN : REQ_QUERY,
                          pick_speed(), wall_tick, $urandom_range(0, 3) == 0));
        end
        advance_tick();
        push_req(mk_req(REQ_STOP, pick_speed(), wall_tick, $urandom_range(0, 2) == 0));
        added += queries + 2;
      end
    end
  endtask

  task automatic wait_drained();
    while (n_in != n_queued || n_rsp != n_in) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_mstep(input logic [MSTEP_W-1:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    mstep_now = v;
    n_settings++;
  endtask

  initial begin
    logic [MSTEP_W-1:0] settings[5];
    int                 lengths[5];
    int                 p;
    settings = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd0};
    settings[4] = MSTEP_W'($urandom_range(1, 256));
    lengths = '{300, 300, 200, 300, 400};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed requests at the reset microstep setting.
    push_req(mk_req(REQ_QUERY, 16'h0000, 32'h0000_0000, 1'b0));
    push_req(mk_req(REQ_UP, 16'hFFFF, 32'h0000_0000, 1'b1));
    push_req(mk_req(REQ_QUERY, 16'h1234, 32'hFFFF_FFFF, 1'b0));
    push_req(mk_req(REQ_STOP, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
    push_req(mk_req(REQ_STOP, 16'h0000, 32'h0000_0010, 1'b0));
    push_req(mk_req(REQ_DOWN, 16'h0100, 32'h0000_0020, 1'b1));
    push_req(mk_req(REQ_DOWN, 16'hFFFF, 32'h0000_0064, 1'b0));
    push_req(mk_req(REQ_DOWN, 16'h0001, 32'h0000_0070, 1'b0));
    push_req(mk_req(REQ_QUERY, 16'hFFFF, 32'h0000_0400, 1'b1));
    push_req(mk_req(REQ_STOP, 16'h0000, 32'h0000_0063, 1'b0));
    push_req(mk_req(REQ_UP, 16'h0100, 32'h0000_000A, 1'b0));
    push_req(mk_req(REQ_STOP, 16'h0000, 32'h0000_040A, 1'b0));
    push_req(mk_req(REQ_DOWN, 16'h0001, 32'h0000_0005, 1'b0));
    push_req(mk_req(REQ_STOP, 16'h0000, 32'h0001_0000, 1'b1));
    push_req(mk_req(REQ_STOP, 16'hFFFF, 32'h8000_0000, 1'b1));
    push_req(mk_req(REQ_DOWN, 16'h0200, 32'h0000_0100, 1'b0));
    push_req(mk_req(REQ_STOP, 16'h0000, 32'h0000_0500, 1'b0));
    push_req(mk_req(REQ_UP, 16'h0000, 32'h0000_0600, 1'b0));
    push_req(mk_req(REQ_QUERY, 16'h0000, 32'hFFFF_0000, 1'b0));
    push_req(mk_req(REQ_UP, 16'h8000, 32'hFFFF_FF00, 1'b0));
    push_req(mk_req(REQ_QUERY, 16'h0000, 32'h0000_0100, 1'b0));
    push_req(mk_req(REQ_STOP, 16'h0000, 32'h0000_0200, 1'b0));
    push_req(mk_req(REQ_DOWN, 16'hFFFF, 32'h0000_0000, 1'b0));
    push_req(mk_req(REQ_STOP, 16'h0000, 32'hFFFF_FFFF, 1'b0));

    for (p = 0; p < 5; p++) begin
      wait_drained();
      write_mstep(settings[p]);
      queue_traffic(lengths[p]);
      if (p == 1) long_hold_req = 1'b1;
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d responses to %0d requests over %0d microstep settings.",
             n_rsp, n_in, n_settings);
    $display("Busy refusals: %0d, home faults: %0d, mismatches: %0d.",
             n_busy, n_fault, n_err);
    if (n_err == 0) begin
      $display("dumper_angle_tracker_unit_tb OK");
    end else begin
      $display("dumper_angle_tracker_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
